/* sv/kar_pkg.sv */
// Shared types and constants for the key auto-repeat scanner.
package kar_pkg;

	// Fixed field widths of the stream payloads
	localparam int FIELD_W   = 14;
	localparam int ELAPSED_W = 16;
	localparam int CFG_W     = 16;

	// Stream payload layout, lowest bits first
	localparam int PHYS_LSB   = 0;
	localparam int INJ_LSB    = PHYS_LSB + FIELD_W;
	localparam int ELAP_LSB   = INJ_LSB + FIELD_W;
	localparam int IN_USED_W  = ELAP_LSB + ELAPSED_W;
	localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

	localparam int HELD_LSB    = 0;
	localparam int PRESS_LSB   = HELD_LSB + FIELD_W;
	localparam int RPT_LSB     = PRESS_LSB + FIELD_W;
	localparam int OUT_USED_W  = RPT_LSB + FIELD_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

	// Parameter defaults
	localparam int NUM_KEYS_DEF  = 14;
	localparam int TIME_BITS_DEF = 16;

	// APB register map
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_DELAY  = 1'b0;
	localparam logic REG_PERIOD = 1'b1;

	localparam logic [CFG_W-1:0] DELAY_RST  = 16'd400;
	localparam logic [CFG_W-1:0] PERIOD_RST = 16'd90;

	typedef struct packed {
		logic [CFG_W-1:0] delay;
		logic [CFG_W-1:0] period;
	} cfg_t;

	// Per-key update control from the scanner to each key cell
	typedef struct packed {
		logic upd;      // frame advances this cycle
		logic held;     // key held this frame
		logic was_held; // key held in previous frame
	} key_ctl_t;

endpackage

/* sv/kar_cfg_regs.sv */
// APB register file for the repeat delay and period.
module kar_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [kar_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [kar_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [kar_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output kar_pkg::cfg_t                     cfg
);
	import kar_pkg::*;

	logic             wr_en;
	logic             reg_sel;
	logic [CFG_W-1:0] delay_q;
	logic [CFG_W-1:0] period_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= DELAY_RST;
			period_q <= PERIOD_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_DELAY:  delay_q  <= pwdata[CFG_W-1:0];
				REG_PERIOD: period_q <= pwdata[CFG_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_DELAY:  prdata = APB_DATA_W'(delay_q);
			REG_PERIOD: prdata = APB_DATA_W'(period_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.delay  = delay_q;
	assign cfg.period = period_q;

endmodule

/* sv/kar_key_cell.sv */
// One key's hold timer and repeat accumulator.
module kar_key_cell #(
	parameter int TIME_BITS = kar_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kar_pkg::key_ctl_t    ctl,
	input  kar_pkg::cfg_t        cfg,
	input  logic [TIME_BITS-1:0] dt,
	output logic                 fire
);
	import kar_pkg::*;

	localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

	logic [TIME_BITS-1:0] hold_q;
	logic [TIME_BITS-1:0] accum_q;
	logic [TIME_BITS:0]   hold_sum;
	logic [TIME_BITS:0]   accum_sum;
	logic [TIME_BITS-1:0] hold_sat;
	logic [TIME_BITS-1:0] accum_sat;
	logic [CMP_W-1:0]     accum_diff;
	logic                 past_delay;
	logic                 period_hit;
	logic [TIME_BITS-1:0] hold_nxt;
	logic [TIME_BITS-1:0] accum_nxt;

	// saturating adds
	assign hold_sum   = {1'b0, hold_q} + {1'b0, dt};
	assign accum_sum  = {1'b0, accum_q} + {1'b0, dt};
	assign hold_sat   = hold_sum[TIME_BITS] ? '1 : hold_sum[TIME_BITS-1:0];
	assign accum_sat  = accum_sum[TIME_BITS] ? '1 : accum_sum[TIME_BITS-1:0];

	assign past_delay = CMP_W'(hold_sat) >= CMP_W'(cfg.delay);
	assign period_hit = CMP_W'(accum_sat) >= CMP_W'(cfg.period);
	assign accum_diff = CMP_W'(accum_sat) - CMP_W'(cfg.period);

	always_comb begin
		hold_nxt  = '0;
		accum_nxt = '0;
		fire      = 1'b0;
		if (ctl.held && !ctl.was_held) begin
			fire = 1'b1;
		end else if (ctl.held) begin
			hold_nxt  = hold_sat;
			accum_nxt = accum_q;
			if (past_delay) begin
				accum_nxt = accum_sat;
				if (period_hit) begin
					// diff fits, accumulator was at least one period
					accum_nxt = accum_diff[TIME_BITS-1:0];
					fire      = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= '0;
			accum_q <= '0;
		end else if (ctl.upd) begin
			hold_q  <= hold_nxt;
			accum_q <= accum_nxt;
		end
	end

endmodule

/* sv/key_autorepeat_scanner.sv */
// Top level of the key auto-repeat scanner: frame register, key cells, result register.
//
// Channel  Dir  Handshake          Payload
// s_axis   in   tvalid/tready      tdata: physical_keys, injected_keys, elapsed_ms
// m_axis   out  tvalid/tready      tdata: held_keys, pressed_keys, repeat_keys
// apb      in   psel/penable/pready  delay at 0x0, period at 0x4
//
// One frame per cycle sustained while m_tready stays high; a frame's result passes
// through the frame register, then the result register, before it reaches m_axis.
// The key update is one saturating add, compare and subtract per key, all
// keys side by side between the frame register and the result register.
// arst_n clears timers, previous-held map, valids; registers reload defaults.
// A stalled result holds in the result register while one more frame waits
// in the frame register; only then does s_tready drop.
module key_autorepeat_scanner #(
	parameter int NUM_KEYS  = kar_pkg::NUM_KEYS_DEF,
	parameter int TIME_BITS = kar_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// frame in
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [13:0] physical_keys, [27:14] injected_keys, [43:28] elapsed_ms, [47:44] zero
	input  logic [kar_pkg::IN_TDATA_W-1:0]    s_tdata,
	// result out
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [13:0] held_keys, [27:14] pressed_keys, [41:28] repeat_keys, [47:42] zero
	output logic [kar_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [kar_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [kar_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [kar_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import kar_pkg::*;

	localparam int CMP_W = (TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	cfg_t cfg;

	// frame register
	logic                 valid_s1;
	logic [IN_USED_W-1:0] frame_s1;

	// result register
	logic                 out_valid_q;
	logic [FIELD_W-1:0]   out_held_q;
	logic [FIELD_W-1:0]   out_press_q;
	logic [FIELD_W-1:0]   out_rpt_q;

	logic                 advance;
	logic                 upd;
	logic [FIELD_W-1:0]   phys;
	logic [FIELD_W-1:0]   inj;
	logic [ELAPSED_W-1:0] elapsed;
	logic [CMP_W-1:0]     elapsed_w;
	logic [CMP_W-1:0]     dt_w;
	logic [TIME_BITS-1:0] dt;

	logic [NUM_KEYS-1:0]  held;
	logic [NUM_KEYS-1:0]  pressed;
	logic [NUM_KEYS-1:0]  fire;
	logic [NUM_KEYS-1:0]  last_held_q;

	logic [FIELD_W-1:0]   held_f;
	logic [FIELD_W-1:0]   press_f;
	logic [FIELD_W-1:0]   rpt_f;

	kar_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// result register frees when empty or taken; frame register frees when it moves on
	assign advance  = !out_valid_q || m_tready;
	assign upd      = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			frame_s1 <= s_tdata[IN_USED_W-1:0];
		end
	end

	assign phys    = frame_s1[PHYS_LSB +: FIELD_W];
	assign inj     = frame_s1[INJ_LSB +: FIELD_W];
	assign elapsed = frame_s1[ELAP_LSB +: ELAPSED_W];

	// clamp elapsed time to the timer range
	assign elapsed_w = CMP_W'(elapsed);
	assign dt_w      = (elapsed_w > CMP_W'(TIME_MAX)) ? CMP_W'(TIME_MAX) : elapsed_w;
	assign dt        = dt_w[TIME_BITS-1:0];

	// keys past the field width never see a press
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
		key_ctl_t ctl;

		if (k < FIELD_W) begin : g_in
			assign held[k] = phys[k] | inj[k];
		end else begin : g_none
			assign held[k] = 1'b0;
		end

		assign ctl.upd      = upd;
		assign ctl.held     = held[k];
		assign ctl.was_held = last_held_q[k];

		kar_key_cell #(
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.cfg    (cfg),
			.dt     (dt),
			.fire   (fire[k])
		);
	end

	assign pressed = held & ~last_held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_held_q <= '0;
		end else if (upd) begin
			last_held_q <= held;
		end
	end

	// map key bitmaps onto the fixed output fields
	for (genvar j = 0; j < FIELD_W; j++) begin : g_field
		if (j < NUM_KEYS) begin : g_key_bit
			assign held_f[j]  = held[j];
			assign press_f[j] = pressed[j];
			assign rpt_f[j]   = fire[j];
		end else begin : g_zero
			assign held_f[j]  = 1'b0;
			assign press_f[j] = 1'b0;
			assign rpt_f[j]   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			out_held_q  <= held_f;
			out_press_q <= press_f;
			out_rpt_q   <= rpt_f;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({out_rpt_q, out_press_q, out_held_q});

endmodule

/* sim/kar_checker.sv */
// Scoreboard for the key auto-repeat scanner: watches the streams and APB, predicts, compares.
module kar_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [kar_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [kar_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [kar_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [kar_pkg::APB_DATA_W-1:0]  pwdata,
	output int                              errors,
	output int                              outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import kar_pkg::*;

	localparam int NKEYS = NUM_KEYS_DEF;

	// first member lands in the top bits, so this matches m_tdata[41:0]
	typedef struct packed {
		logic [FIELD_W-1:0] repeats;
		logic [FIELD_W-1:0] pressed;
		logic [FIELD_W-1:0] held;
	} key_report_t;

	logic [CFG_W-1:0]     delay_ms;
	logic [CFG_W-1:0]     period_ms;
	logic [NKEYS-1:0]     prev_held;
	logic [ELAPSED_W-1:0] hold_ms [NKEYS];
	logic [ELAPSED_W-1:0] accum_ms [NKEYS];
	key_report_t          expected_reports [$];
	int                   err_cnt = 0;

	// one scan frame through the typematic state; timers saturate at all ones
	function automatic key_report_t scan_frame(input logic [FIELD_W-1:0] phys,
			input logic [FIELD_W-1:0] inj, input logic [ELAPSED_W-1:0] el);
		logic [FIELD_W-1:0] held;
		logic [FIELD_W-1:0] fire;
		logic [ELAPSED_W:0] sum;
		key_report_t        rep;
		int                 k;
		held = phys | inj;
		fire = '0;
		for (k = 0; k < NKEYS; k++) begin
			if (!held[k]) begin
				hold_ms[k] = '0;
				accum_ms[k] = '0;
			end else if (!prev_held[k]) begin
				hold_ms[k] = '0;
				accum_ms[k] = '0;
				fire[k] = 1'b1;
			end else begin
				sum = hold_ms[k] + el;
				hold_ms[k] = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
				if (hold_ms[k] >= delay_ms) begin
					sum = accum_ms[k] + el;
					accum_ms[k] = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
					if (accum_ms[k] >= period_ms) begin
						accum_ms[k] = accum_ms[k] - period_ms;
						fire[k] = 1'b1;
					end
				end
			end
		end
		rep.held = held;
		rep.pressed = held & ~prev_held;
		rep.repeats = fire;
		prev_held = held;
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		key_report_t got;
		key_report_t exp_rep;
		if (!arst_n) begin
			delay_ms = DELAY_RST;
			period_ms = PERIOD_RST;
			prev_held = '0;
			for (int k = 0; k < NKEYS; k++) begin
				hold_ms[k] = '0;
				accum_ms[k] = '0;
			end
			expected_reports.delete();
			outstanding <= 0;
			errors <= err_cnt;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_DELAY)
					delay_ms = pwdata[CFG_W-1:0];
				else
					period_ms = pwdata[CFG_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				got = key_report_t'(m_tdata[OUT_USED_W-1:0]);
				if (expected_reports.size() == 0) begin
					err_cnt++;
					$display("%t: result %h arrived with nothing expected", $time, got);
				end else begin
					exp_rep = expected_reports.pop_front();
					if (got.held !== exp_rep.held) begin
						err_cnt++;
						$display("%t: held_keys expected %h got %h",
							$time, exp_rep.held, got.held);
					end
					if (got.pressed !== exp_rep.pressed) begin
						err_cnt++;
						$display("%t: pressed_keys expected %h got %h",
							$time, exp_rep.pressed, got.pressed);
					end
					if (got.repeats !== exp_rep.repeats) begin
						err_cnt++;
						$display("%t: repeat_keys expected %h got %h",
							$time, exp_rep.repeats, got.repeats);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_reports.push_back(scan_frame(s_tdata[PHYS_LSB +: FIELD_W],
					s_tdata[INJ_LSB +: FIELD_W], s_tdata[ELAP_LSB +: ELAPSED_W]));
			outstanding <= expected_reports.size();
			errors <= err_cnt;
		end
	end

endmodule

/* sim/key_autorepeat_scanner_tb.sv */
// Testbench top for the key auto-repeat scanner: clock, reset, frame and APB stimulus, verdict.
module key_autorepeat_scanner_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kar_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	int errors;
	int outstanding;

	// quiet: no idle cycles on either side while set
	bit                 quiet = 1'b0;
	int                 frames_sent = 0;
	int                 settings_used = 1;
	int                 cur_delay = int'(DELAY_RST);
	int                 cur_period = int'(PERIOD_RST);
	// key map the random sequences evolve from frame to frame
	logic [FIELD_W-1:0] key_map = '0;

	key_autorepeat_scanner DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	kar_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.errors     (errors),
		.outstanding(outstanding)
	);

	always #2 clk = ~clk;

	// result side: m_tready low about 36 percent of the time unless quiet
	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(0, 99) >= 36);
	end

	// One frame transfer. An idle gap of random length comes first; tvalid is
	// left high afterwards so back-to-back frames never pulse it low.
	task automatic send_frame(input logic [FIELD_W-1:0] phys,
			input logic [FIELD_W-1:0] inj, input logic [ELAPSED_W-1:0] el);
		int gap;
		gap = 0;
		if (!quiet)
			while ($urandom_range(0, 99) < 36)
				gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W-IN_USED_W){1'b0}}, el, inj, phys};
		do @(posedge clk); while (!s_tready);
		frames_sent++;
	endtask

	// Stop sending and wait for every predicted result, then for the
	// pipeline depth (two registers) plus margin.
	task automatic settle_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic reg_write(input logic idx, input logic [CFG_W-1:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {{(APB_DATA_W-CFG_W){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(input logic [CFG_W-1:0] dly, input logic [CFG_W-1:0] per);
		reg_write(REG_DELAY, dly);
		reg_write(REG_PERIOD, per);
		cur_delay = int'(dly);
		cur_period = int'(per);
		settings_used++;
	endtask

	// Mostly a slowly changing key map split between physical and injected
	// bits, so keys stay held long enough to reach the delay and repeat.
	// About one frame in ten is unrelated noise on both bitmaps.
	task automatic random_frame();
		int                 pick;
		int                 span;
		int                 k;
		logic [FIELD_W-1:0] m1;
		logic [FIELD_W-1:0] m2;
		logic [FIELD_W-1:0] phys;
		logic [FIELD_W-1:0] inj;
		logic [ELAPSED_W-1:0] el;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			for (k = 0; k < FIELD_W; k++)
				if ($urandom_range(0, 19) == 0)
					key_map[k] = ~key_map[k];
		end else if (pick < 90) begin
			key_map = FIELD_W'($urandom);
		end
		m1 = FIELD_W'($urandom);
		m2 = FIELD_W'($urandom);
		phys = key_map & m1;
		inj = key_map & (~m1 | m2);
		if (pick >= 90) begin
			phys = FIELD_W'($urandom);
			inj = FIELD_W'($urandom);
			key_map = phys | inj;
		end
		// elapsed time scaled to the current period and delay, sometimes full range
		pick = $urandom_range(0, 99);
		if (pick < 65)
			span = 2 * cur_period + 1;
		else if (pick < 90)
			span = cur_delay + 1;
		else
			span = 65535;
		if (span > 65535)
			span = 65535;
		el = ELAPSED_W'($urandom_range(0, span));
		send_frame(phys, inj, el);
	endtask

	initial begin
		logic [CFG_W-1:0] dly_tab [6];
		logic [CFG_W-1:0] per_tab [6];
		int               p;
		int               i;
		dly_tab = '{16'd1, 16'd400, 16'hFFFF, 16'd40, 16'd1, 16'd150};
		per_tab = '{16'd1, 16'd90, 16'hFFFF, 16'd7, 16'hFFFF, 16'd25};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: 400 ms delay, 90 ms period
		send_frame(14'h0001, 14'h0000, 16'd0);
		send_frame(14'h0001, 14'h0000, 16'd400);
		send_frame(14'h0000, 14'h0001, 16'd90);
		settle_results();

		// short delay and period; extremes of every field
		set_timing(16'd5, 16'd3);
		send_frame(14'h0000, 14'h0000, 16'd0);
		send_frame(14'h3FFF, 14'h0000, 16'd0);
		send_frame(14'h0000, 14'h3FFF, 16'd2);
		send_frame(14'h3FFF, 14'h3FFF, 16'd3);
		// saturating hold timer and accumulator
		send_frame(14'h2AAA, 14'h1555, 16'hFFFF);
		// backlog: one period comes off per frame, so zero elapsed still fires
		send_frame(14'h1555, 14'h2AAA, 16'd0);
		send_frame(14'h3FFF, 14'h0000, 16'd0);
		send_frame(14'h3FFF, 14'h0000, 16'hFFFF);
		// partial release, then swap which keys are down
		send_frame(14'h00FF, 14'h0000, 16'd10);
		send_frame(14'h0000, 14'h3F00, 16'd1);
		send_frame(14'h0000, 14'h0000, 16'h8000);
		settle_results();

		// zero delay and zero period: held keys fire every frame
		set_timing(16'd0, 16'd0);
		send_frame(14'h2001, 14'h0000, 16'd0);
		send_frame(14'h2001, 14'h0000, 16'd0);
		send_frame(14'h0000, 14'h2001, 16'd7);
		settle_results();

		// full-scale delay and period
		set_timing(16'hFFFF, 16'hFFFF);
		send_frame(14'h0000, 14'h0810, 16'd1);
		send_frame(14'h0810, 14'h0000, 16'hFFFF);
		send_frame(14'h0810, 14'h0810, 16'hFFFF);
		send_frame(14'h0010, 14'h0000, 16'd1);
		send_frame(14'h0000, 14'h0000, 16'd0);

		// random sequences under several register settings
		for (p = 0; p < 6; p++) begin
			settle_results();
			set_timing(dly_tab[p], per_tab[p]);
			quiet = (p == 4);
			for (i = 0; i < 172; i++) begin
				random_frame();
				// sender holds off mid-stream until the results catch up
				if (p == 3 && i == 86)
					settle_results();
			end
		end
		quiet = 1'b0;
		settle_results();
		repeat (8) @(posedge clk);

		$display("Sent %0d scan frames under %0d delay/period settings,",
			frames_sent, settings_used);
		$display("  with zero, unit and full-scale timing and saturating elapsed times.");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#400us;
		$display("TB_ERROR");
		$finish;
	end

endmodule
